/* hdl/q4k_block_dot_product_assert.svh */
// ---------------------------------------------------------------------------
// q4k_block_dot_product_assert.svh
// Assertion macros used by the checker file q4k_chk.sv.
// ---------------------------------------------------------------------------
`ifndef Q4K_BLOCK_DOT_PRODUCT_ASSERT_SVH
`define Q4K_BLOCK_DOT_PRODUCT_ASSERT_SVH

// same-cycle implication
`define Q4K_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("q4k assertion failed");

// next-cycle implication
`define Q4K_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("q4k assertion failed");

`endif

/* hdl/q4k_pkg.sv */
// ---------------------------------------------------------------------------
// q4k_pkg
// Shared types, constants and format helpers for the Q4_K dot product.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package q4k_pkg;

   localparam logic [31:0] FP32_CANON_NAN = 32'h7FC0_0000;
   localparam logic [31:0] FP32_INF       = 32'h7F80_0000;
   localparam logic [31:0] FP32_NEG_ZERO  = 32'h8000_0000;
   localparam logic [31:0] FP32_POS_ZERO  = 32'h0000_0000;
   localparam logic [31:0] FP32_RECIP_15  = 32'h3D88_8889;
   localparam int          SUB_SCALES     = 8;
   localparam int          SUB_W          = 6;

   typedef struct packed {
      logic        valid;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } fma_req_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] result;
   } fma_rsp_type;

   // fp16 bits to fp32 bits, exact
   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [4:0]  ex;
      logic [9:0]  man;
      logic [3:0]  p;
      logic [3:0]  e;
      logic [19:0] sh;
      logic [31:0] r;
      begin
         ex  = h[14:10];
         man = h[9:0];
         p   = 4'd0;
         for (int i = 0; i < 10; i++) begin
            if (man[i]) p = 4'(i);
         end
         e  = 4'd10 - p;
         sh = {10'b0, man} << e;
         if (ex == 5'd0) begin
            if (man == 10'd0) r = {h[15], 31'b0};
            else r = {h[15], 8'(8'd113 - {4'b0, e}), sh[9:0], 13'b0};
         end else if (ex == 5'h1F) begin
            r = {h[15], 8'hFF, man, 13'b0};
         end else begin
            r = {h[15], 8'({3'b0, ex} + 8'd112), man, 13'b0};
         end
         return r;
      end
   endfunction

   // small unsigned integer to fp32 bits, exact
   function automatic logic [31:0] uint_to_single(input logic [SUB_W-1:0] v);
      logic [4:0]  p;
      logic [29:0] w;
      logic [31:0] r;
      begin
         p = 5'd0;
         for (int i = 0; i < SUB_W; i++) begin
            if (v[i]) p = 5'(i);
         end
         w = {24'b0, v} << (5'd23 - p);
         if (v == '0) r = FP32_POS_ZERO;
         else r = {1'b0, 8'(8'd127 + {3'b0, p}), w[22:0]};
         return r;
      end
   endfunction

endpackage

`default_nettype wire

/* hdl/q4k_fma.sv */
// ---------------------------------------------------------------------------
// q4k_fma
// Four-stage fp32 fused multiply-add, single rounding to nearest even.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module q4k_fma (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire q4k_pkg::fma_req_type fma_req,
   output q4k_pkg::fma_rsp_type      fma_rsp
);
   import q4k_pkg::*;

   function automatic logic [76:0] shr_sticky(input logic [76:0] v, input logic [10:0] d);
      logic [76:0] r;
      logic [76:0] mask;
      logic        lost;
      begin
         if (d > 11'd76) begin
            r    = '0;
            lost = |v;
         end else begin
            r    = v >> d;
            mask = ~({77{1'b1}} << d);
            lost = |(v & mask);
         end
         r[0] = r[0] | lost;
         return r;
      end
   endfunction

   // stage 1: unpack, specials, mantissa product
   logic        a_zero, b_zero, c_zero, a_inf, b_inf, c_inf, a_nan, b_nan, c_nan;
   logic [23:0] sig_a, sig_b, sig_c;
   logic [8:0]  exp_a, exp_b, exp_c;
   logic        sp, any_nan;

   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic [47:0]        mp1_ff;
   logic [23:0]        mc1_ff;
   logic signed [10:0] xp1_ff, xc1_ff;
   logic               sp1_ff, sc1_ff, pz1_ff, cz1_ff, nan1_ff, inf1_ff, infs1_ff;

   always_comb begin
      a_zero = fma_req.a[30:0] == 31'd0;
      b_zero = fma_req.b[30:0] == 31'd0;
      c_zero = fma_req.c[30:0] == 31'd0;
      a_inf  = fma_req.a[30:23] == 8'hFF && fma_req.a[22:0] == 23'd0;
      b_inf  = fma_req.b[30:23] == 8'hFF && fma_req.b[22:0] == 23'd0;
      c_inf  = fma_req.c[30:23] == 8'hFF && fma_req.c[22:0] == 23'd0;
      a_nan  = fma_req.a[30:23] == 8'hFF && fma_req.a[22:0] != 23'd0;
      b_nan  = fma_req.b[30:23] == 8'hFF && fma_req.b[22:0] != 23'd0;
      c_nan  = fma_req.c[30:23] == 8'hFF && fma_req.c[22:0] != 23'd0;
      sig_a  = {fma_req.a[30:23] != 8'd0, fma_req.a[22:0]};
      sig_b  = {fma_req.b[30:23] != 8'd0, fma_req.b[22:0]};
      sig_c  = {fma_req.c[30:23] != 8'd0, fma_req.c[22:0]};
      exp_a  = (fma_req.a[30:23] == 8'd0) ? 9'd1 : {1'b0, fma_req.a[30:23]};
      exp_b  = (fma_req.b[30:23] == 8'd0) ? 9'd1 : {1'b0, fma_req.b[30:23]};
      exp_c  = (fma_req.c[30:23] == 8'd0) ? 9'd1 : {1'b0, fma_req.c[30:23]};
      sp     = fma_req.a[31] ^ fma_req.b[31];
      any_nan = a_nan | b_nan | c_nan | (a_inf & b_zero) | (b_inf & a_zero)
              | ((a_inf | b_inf) & c_inf & (sp != fma_req.c[31]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= fma_req.valid;
      end
      mp1_ff   <= sig_a * sig_b;
      mc1_ff   <= sig_c;
      xp1_ff   <= 11'(signed'({2'b0, exp_a} + {2'b0, exp_b}) - 11'sd28);
      xc1_ff   <= 11'(signed'({2'b0, exp_c}) + 11'sd98);
      sp1_ff   <= sp;
      sc1_ff   <= fma_req.c[31];
      pz1_ff   <= a_zero | b_zero;
      cz1_ff   <= c_zero;
      nan1_ff  <= any_nan;
      inf1_ff  <= ~any_nan & (a_inf | b_inf | c_inf);
      infs1_ff <= (a_inf | b_inf) ? sp : fma_req.c[31];
   end

   // stage 2: align and add
   logic signed [11:0] dx;
   logic [76:0]        pm, cm, pa, cb;
   logic signed [10:0] x2_in;
   logic [77:0]        sum2_in;
   logic               sgn2_in;

   logic [77:0]        s2_ff;
   logic signed [10:0] x2_ff;
   logic               sgn2_ff, nan2_ff, inf2_ff, infs2_ff;

   always_comb begin
      dx = 12'(xp1_ff) - 12'(xc1_ff);
      pm = {mp1_ff, 29'b0};
      cm = {mc1_ff, 53'b0};
      priority if (pz1_ff) begin
         pa = '0; cb = cm; x2_in = xc1_ff;
      end else if (cz1_ff) begin
         pa = pm; cb = '0; x2_in = xp1_ff;
      end else if (!dx[11]) begin
         pa = pm; cb = shr_sticky(cm, dx[10:0]); x2_in = xp1_ff;
      end else begin
         pa = shr_sticky(pm, 11'(-dx)); cb = cm; x2_in = xc1_ff;
      end
      if (sp1_ff == sc1_ff) begin
         sum2_in = {1'b0, pa} + {1'b0, cb};
         sgn2_in = sp1_ff;
      end else if (pa >= cb) begin
         sum2_in = {1'b0, pa} - {1'b0, cb};
         sgn2_in = sp1_ff;
      end else begin
         sum2_in = {1'b0, cb} - {1'b0, pa};
         sgn2_in = sc1_ff;
      end
      if (sum2_in == '0) sgn2_in = sp1_ff & sc1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      s2_ff    <= sum2_in;
      x2_ff    <= x2_in;
      sgn2_ff  <= sgn2_in;
      nan2_ff  <= nan1_ff;
      inf2_ff  <= inf1_ff;
      infs2_ff <= infs1_ff;
   end

   // stage 3: leading one and rounding position
   logic [6:0]         k3;
   logic signed [11:0] lk3, ls3, l3_in;

   logic [77:0]        s3_ff;
   logic signed [11:0] l3_ff;
   logic signed [10:0] x3_ff;
   logic               sgn3_ff, nan3_ff, inf3_ff, infs3_ff, zero3_ff;

   always_comb begin
      k3 = 7'd0;
      for (int i = 0; i < 78; i++) begin
         if (s2_ff[i]) k3 = 7'(i);
      end
      lk3   = signed'({5'b0, k3}) - 12'sd23;
      ls3   = 12'sd152 - 12'(x2_ff);
      l3_in = (lk3 > ls3) ? lk3 : ls3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      s3_ff    <= s2_ff;
      l3_ff    <= l3_in;
      x3_ff    <= x2_ff;
      sgn3_ff  <= sgn2_ff;
      nan3_ff  <= nan2_ff;
      inf3_ff  <= inf2_ff;
      infs3_ff <= infs2_ff;
      zero3_ff <= s2_ff == '0;
   end

   // stage 4: shift, round, pack
   logic [7:0]         ru;
   logic [77:0]        v_r, v_l, g_vec, st_mask;
   logic               g, st, rup;
   logic [23:0]        mant;
   logic [24:0]        m25;
   logic signed [11:0] base, field;
   logic [22:0]        frac;
   logic [31:0]        res_in;
   logic [31:0]        res_ff;

   always_comb begin
      ru      = (l3_ff > 12'sd127) ? 8'd127 : (l3_ff[11] ? 8'd0 : l3_ff[7:0]);
      v_r     = s3_ff >> ru;
      v_l     = s3_ff << 5'(-l3_ff);
      g_vec   = s3_ff >> (ru - 8'd1);
      st_mask = ~({78{1'b1}} << (ru - 8'd1));
      g       = (ru != 8'd0) & g_vec[0];
      st      = (ru > 8'd1) & (|(s3_ff & st_mask));
      mant    = l3_ff[11] ? v_l[23:0] : v_r[23:0];
      rup     = g & (st | mant[0]);
      m25     = {1'b0, mant} + 25'(rup);
      base    = l3_ff + 12'(x3_ff) - 12'sd152;
      field   = base + (m25[24] ? 12'sd2 : (m25[23] ? 12'sd1 : 12'sd0));
      frac    = m25[24] ? 23'd0 : m25[22:0];
      priority if (nan3_ff) begin
         res_in = FP32_CANON_NAN;
      end else if (inf3_ff) begin
         res_in = {infs3_ff, FP32_INF[30:0]};
      end else if (zero3_ff) begin
         res_in = {sgn3_ff, 31'b0};
      end else if (field >= 12'sd255) begin
         res_in = {sgn3_ff, FP32_INF[30:0]};
      end else begin
         res_in = {sgn3_ff, field[7:0], frac};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      res_ff <= res_in;
   end

   assign fma_rsp.valid  = v4_ff;
   assign fma_rsp.result = res_ff;

endmodule

`default_nettype wire

/* hdl/q4k_block_dot_product.sv */
// ---------------------------------------------------------------------------
// q4k_block_dot_product
// Q4_K block dequantize and fp32 row dot product over one shared fma unit.
// ---------------------------------------------------------------------------
// Header beat: taken in ST_IDLE without leaving it, so req_tready stays high.
// Quant beat: six dependent ops (scale, recip, deq lo, acc lo, deq hi, acc hi)
//   run one at a time through the 4-stage fma pipeline, req_tready low meanwhile.
// Row end: after the last op, ST_OUT loads dot_sum into the output register
//   once the previous output beat is not stalled, then returns to ST_IDLE.
// Synchronous reset clears scale, bias, sub-scales, counter and accumulator.
`timescale 1ns / 1ps
`default_nettype none

module q4k_block_dot_product (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // block_scale, block_bias, packed_scales, quant_byte, act_even, act_odd
   input  wire logic [151:0] req_tdata,
   // req_type
   input  wire logic         req_tuser,
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // dot_sum
   output logic [31:0]       rsp_tdata
);
   import q4k_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT} state_type;
   typedef enum logic [2:0] {
      SP_SCALE, SP_RECIP, SP_DEQ_LO, SP_ACC_LO, SP_DEQ_HI, SP_ACC_HI
   } step_type;

   state_type         state_ff;
   step_type          step_ff;
   logic [31:0]       scale_ff, bias_ff, acc_ff, tmp_ff, ss_ff;
   logic [SUB_W-1:0]  sub_ff [SUB_SCALES];
   logic [6:0]        cnt_ff;
   logic [7:0]        qb_ff;
   logic [31:0]       act_even_ff, act_odd_ff;
   logic              last_ff;
   logic              rsp_valid_ff;
   logic [31:0]       rsp_data_ff;

   fma_req_type fma_req;
   fma_rsp_type fma_rsp;

   q4k_fma u_fma (
      .clock   (clock),
      .reset   (reset),
      .fma_req (fma_req),
      .fma_rsp (fma_rsp)
   );

   always_comb begin
      fma_req.valid = state_ff == ST_ISSUE;
      unique case (step_ff)
         SP_SCALE: begin
            fma_req.a = uint_to_single(sub_ff[cnt_ff[6:4]]);
            fma_req.b = scale_ff;
            fma_req.c = FP32_NEG_ZERO;
         end
         SP_RECIP: begin
            fma_req.a = tmp_ff;
            fma_req.b = FP32_RECIP_15;
            fma_req.c = FP32_NEG_ZERO;
         end
         SP_DEQ_LO: begin
            fma_req.a = uint_to_single({2'b0, qb_ff[3:0]});
            fma_req.b = ss_ff;
            fma_req.c = bias_ff;
         end
         SP_ACC_LO: begin
            fma_req.a = tmp_ff;
            fma_req.b = act_even_ff;
            fma_req.c = acc_ff;
         end
         SP_DEQ_HI: begin
            fma_req.a = uint_to_single({2'b0, qb_ff[7:4]});
            fma_req.b = ss_ff;
            fma_req.c = bias_ff;
         end
         SP_ACC_HI: begin
            fma_req.a = tmp_ff;
            fma_req.b = act_odd_ff;
            fma_req.c = acc_ff;
         end
         default: begin
            fma_req.a = FP32_POS_ZERO;
            fma_req.b = FP32_POS_ZERO;
            fma_req.c = FP32_POS_ZERO;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= SP_SCALE;
         scale_ff     <= FP32_POS_ZERO;
         bias_ff      <= FP32_POS_ZERO;
         acc_ff       <= FP32_POS_ZERO;
         cnt_ff       <= 7'd0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SUB_SCALES; i++) sub_ff[i] <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != ST_OUT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  if (!req_tuser) begin
                     scale_ff <= half_to_single(req_tdata[15:0]);
                     bias_ff  <= half_to_single(req_tdata[31:16]);
                     for (int i = 0; i < SUB_SCALES; i++)
                        sub_ff[i] <= req_tdata[32 + SUB_W*i +: SUB_W];
                     cnt_ff <= 7'd0;
                  end else begin
                     qb_ff       <= req_tdata[87:80];
                     act_even_ff <= req_tdata[119:88];
                     act_odd_ff  <= req_tdata[151:120];
                     last_ff     <= req_tlast;
                     step_ff     <= SP_SCALE;
                     state_ff    <= ST_ISSUE;
                  end
               end
            end
            ST_ISSUE: begin
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (fma_rsp.valid) begin
                  unique case (step_ff)
                     SP_RECIP:             ss_ff  <= fma_rsp.result;
                     SP_ACC_LO, SP_ACC_HI: acc_ff <= fma_rsp.result;
                     default:              tmp_ff <= fma_rsp.result;
                  endcase
                  if (step_ff == SP_ACC_HI) begin
                     cnt_ff   <= cnt_ff + 7'd1;
                     state_ff <= last_ff ? ST_OUT : ST_IDLE;
                  end else begin
                     step_ff  <= step_type'(step_ff + 3'd1);
                     state_ff <= ST_ISSUE;
                  end
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= acc_ff;
                  rsp_valid_ff <= 1'b1;
                  acc_ff       <= FP32_POS_ZERO;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

/* hdl/q4k_chk.sv */
// ---------------------------------------------------------------------------
// q4k_chk
// Port-level checker for q4k_block_dot_product, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "q4k_block_dot_product_assert.svh"

module q4k_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   `Q4K_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `Q4K_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `Q4K_ASSERT_NEXT(a_busy_after_quant, clock, reset, req_tvalid && req_tready && req_tuser, !req_tready)
   `Q4K_ASSERT_NEXT(a_ready_after_hdr, clock, reset, req_tvalid && req_tready && !req_tuser, req_tready)
   `Q4K_ASSERT_IMPL(a_idle_no_new_rsp, clock, reset, $rose(rsp_tvalid), req_tready)

endmodule

bind q4k_block_dot_product q4k_chk u_q4k_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
